>>> sv/rmpi_pkg.sv
// Shared types, constants and codes for the recursive priority-inheritance mutex.
package rmpi_pkg;

  localparam int NUM_TASKS   = 16;
  localparam int PRIO_LEVELS = 32;
  localparam int MAX_WAITERS = 16;
  localparam int MAX_DEPTH   = 255;

  localparam int TASK_W  = $clog2(NUM_TASKS);
  localparam int PRIO_W  = $clog2(PRIO_LEVELS);
  localparam int DEPTH_W = 8;

  localparam logic [DEPTH_W-1:0] DEPTH_LIMIT =
    (MAX_DEPTH > 255) ? DEPTH_W'(255) : DEPTH_W'(MAX_DEPTH);
  localparam logic [PRIO_W-1:0] LOWEST_PRIO_RST = PRIO_W'(PRIO_LEVELS - 1);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  typedef enum logic {
    REG_LOWEST_PRIO = 1'b0,
    REG_UNUSED      = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_LOCK    = 2'd0,
    OP_UNLOCK  = 2'd1,
    OP_TRYLOCK = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_GRANTED    = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_BUSY       = 3'd2,
    ST_PARTIAL    = 3'd3,
    ST_RELEASED   = 3'd4,
    ST_NOT_OWNER  = 3'd5,
    ST_QUEUE_FULL = 3'd6,
    ST_DEPTH_OVF  = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TASK_W-1:0] requester_task;
    logic [PRIO_W-1:0] requester_prio;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               resume_valid;
    logic [TASK_W-1:0]  resume_task;
    logic               set_prio_valid;
    logic [TASK_W-1:0]  set_prio_task;
    logic [PRIO_W-1:0]  set_prio_value;
    logic [DEPTH_W-1:0] depth_out;
    logic [PRIO_W-1:0]  ceiling_out;
  } rsp_t;

  typedef struct packed {
    logic [TASK_W-1:0] tid;
    logic [PRIO_W-1:0] prio;
  } waiter_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic pop;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_req;
    logic scan_done;
  } dp_sts_t;

endpackage

>>> sv/rmpi_ctrl.sv
// Sequencer for request decode, waiter pop, ceiling rescan and result hand-off.
module rmpi_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rmpi_pkg::dp_sts_t   sts_i,
  output rmpi_pkg::ctrl_cmd_t cmd_o
);

  rmpi_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rmpi_pkg::S_IDLE: begin
        if (in_valid_i) state_d = rmpi_pkg::S_EXEC;
      end
      rmpi_pkg::S_EXEC: begin
        state_d = sts_i.pop_req ? rmpi_pkg::S_POP : rmpi_pkg::S_FINISH;
      end
      rmpi_pkg::S_POP: begin
        state_d = rmpi_pkg::S_SCAN;
      end
      rmpi_pkg::S_SCAN: begin
        if (sts_i.scan_done) state_d = rmpi_pkg::S_FINISH;
      end
      rmpi_pkg::S_FINISH: begin
        if (out_free) state_d = rmpi_pkg::S_IDLE;
      end
      default: state_d = rmpi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      rmpi_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      rmpi_pkg::S_EXEC: cmd_o.exec = 1'b1;
      rmpi_pkg::S_POP:  cmd_o.pop  = 1'b1;
      rmpi_pkg::S_SCAN: cmd_o.scan = 1'b1;
      rmpi_pkg::S_FINISH: begin
        cmd_o.finish = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmpi_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> sv/rmpi_dp.sv
// Mutex state, waiter ring memory, ceiling rescan and result register.
module rmpi_dp #(
  parameter int MAX_WAITERS = rmpi_pkg::MAX_WAITERS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rmpi_pkg::ctrl_cmd_t         cmd_i,
  output rmpi_pkg::dp_sts_t           sts_o,
  input  rmpi_pkg::req_t              in_req_i,
  input  logic [rmpi_pkg::PRIO_W-1:0] lowest_prio_i,
  output rmpi_pkg::rsp_t              rsp_o
);

  localparam int PTR_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W = $clog2(MAX_WAITERS + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_WAITERS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_WAITERS);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  rmpi_pkg::req_t                  req_q;
  logic                            owner_valid_q;
  logic [rmpi_pkg::TASK_W-1:0]     owner_task_q;
  logic [rmpi_pkg::PRIO_W-1:0]     owner_prio_q;
  logic [rmpi_pkg::DEPTH_W-1:0]    depth_q;
  logic [rmpi_pkg::PRIO_W-1:0]     ceiling_q;
  logic [PTR_W-1:0]                head_q, tail_q, idx_q;
  logic [CNT_W-1:0]                count_q, rem_q;
  logic                            cmp_v_q;
  logic [rmpi_pkg::PRIO_W-1:0]     best_q;
  rmpi_pkg::waiter_t               mem [MAX_WAITERS];
  rmpi_pkg::waiter_t               rd_q;

  rmpi_pkg::status_e               status_q;
  logic                            rv_q, sv_q;
  logic [rmpi_pkg::TASK_W-1:0]     rt_q, st_q;
  logic [rmpi_pkg::PRIO_W-1:0]     sp_q;
  rmpi_pkg::rsp_t                  out_q;

  // request evaluation
  logic                            own_free, own_same, at_limit, q_full;
  logic [rmpi_pkg::PRIO_W-1:0]     min_ceil;
  logic [rmpi_pkg::DEPTH_W-1:0]    dep_dec;
  rmpi_pkg::status_e               ex_status;
  logic                            ex_grant_new, ex_nest, ex_enq, ex_partial, ex_release;
  logic                            ex_sv;
  logic [rmpi_pkg::TASK_W-1:0]     ex_st;
  logic [rmpi_pkg::PRIO_W-1:0]     ex_sp;
  logic                            ex_pop;
  logic                            rd_en;
  logic [PTR_W-1:0]                rd_addr;

  assign own_free = !owner_valid_q;
  assign own_same = owner_task_q == req_q.requester_task;
  assign at_limit = depth_q >= rmpi_pkg::DEPTH_LIMIT;
  assign q_full   = count_q == FULL_CNT;
  assign min_ceil = (req_q.requester_prio < ceiling_q) ? req_q.requester_prio : ceiling_q;
  assign dep_dec  = (depth_q != '0) ? depth_q - rmpi_pkg::DEPTH_W'(1) : depth_q;

  always_comb begin
    ex_status    = rmpi_pkg::ST_BUSY;
    ex_grant_new = 1'b0;
    ex_nest      = 1'b0;
    ex_enq       = 1'b0;
    ex_partial   = 1'b0;
    ex_release   = 1'b0;
    ex_sv        = 1'b0;
    ex_st        = '0;
    ex_sp        = '0;
    ex_pop       = 1'b0;
    case (rmpi_pkg::opcode_e'(req_q.opcode))
      rmpi_pkg::OP_LOCK, rmpi_pkg::OP_TRYLOCK: begin
        if (own_free) begin
          ex_grant_new = 1'b1;
          ex_status    = rmpi_pkg::ST_GRANTED;
        end else if (own_same) begin
          if (at_limit) begin
            ex_status = rmpi_pkg::ST_DEPTH_OVF;
          end else begin
            ex_nest   = 1'b1;
            ex_status = rmpi_pkg::ST_GRANTED;
          end
        end else if (req_q.opcode == rmpi_pkg::OP_LOCK) begin
          if (q_full) begin
            ex_status = rmpi_pkg::ST_QUEUE_FULL;
          end else begin
            ex_enq    = 1'b1;
            ex_status = rmpi_pkg::ST_QUEUED;
            if (owner_prio_q > min_ceil) begin
              ex_sv = 1'b1;
              ex_st = owner_task_q;
              ex_sp = min_ceil;
            end
          end
        end
      end
      rmpi_pkg::OP_UNLOCK: begin
        if (own_free || !own_same) begin
          ex_status = rmpi_pkg::ST_NOT_OWNER;
        end else if (dep_dec != '0) begin
          ex_partial = 1'b1;
          ex_status  = rmpi_pkg::ST_PARTIAL;
        end else begin
          ex_release = 1'b1;
          ex_status  = rmpi_pkg::ST_RELEASED;
          ex_pop     = count_q != '0;
          if (req_q.requester_prio != ceiling_q) begin
            ex_sv = 1'b1;
            ex_st = req_q.requester_task;
            ex_sp = req_q.requester_prio;
          end
        end
      end
      default: ;
    endcase
  end

  assign sts_o.pop_req   = ex_pop;
  assign sts_o.scan_done = (rem_q == '0) && !cmp_v_q;

  assign rd_en   = cmd_i.exec || (cmd_i.scan && rem_q != '0);
  assign rd_addr = cmd_i.exec ? head_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && ex_enq) begin
      mem[tail_q] <= '{tid: req_q.requester_task, prio: req_q.requester_prio};
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_req_i;
    if (cmd_i.exec) begin
      status_q <= ex_status;
      rv_q     <= ex_pop;
      rt_q     <= '0;
      sv_q     <= ex_sv;
      st_q     <= ex_st;
      sp_q     <= ex_sp;
    end
    if (cmd_i.pop) begin
      rt_q   <= rd_q.tid;
      idx_q  <= ring_next(head_q);
      rem_q  <= count_q - CNT_W'(1);
      best_q <= lowest_prio_i;
    end
    if (cmd_i.scan) begin
      if (rem_q != '0) begin
        idx_q <= ring_next(idx_q);
        rem_q <= rem_q - CNT_W'(1);
      end
      if (cmp_v_q && rd_q.prio < best_q) best_q <= rd_q.prio;
    end
    if (cmd_i.finish) begin
      out_q <= '{status:         status_q,
                 resume_valid:   rv_q,
                 resume_task:    rt_q,
                 set_prio_valid: sv_q,
                 set_prio_task:  st_q,
                 set_prio_value: sp_q,
                 depth_out:      depth_q,
                 ceiling_out:    ceiling_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_valid_q <= 1'b0;
      owner_task_q  <= '0;
      owner_prio_q  <= '0;
      depth_q       <= '0;
      ceiling_q     <= rmpi_pkg::LOWEST_PRIO_RST;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      cmp_v_q       <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        if (ex_grant_new) begin
          owner_valid_q <= 1'b1;
          owner_task_q  <= req_q.requester_task;
          owner_prio_q  <= req_q.requester_prio;
          depth_q       <= rmpi_pkg::DEPTH_W'(1);
        end
        if (ex_nest) depth_q <= depth_q + rmpi_pkg::DEPTH_W'(1);
        if (ex_partial) depth_q <= dep_dec;
        if (ex_release) begin
          owner_valid_q <= 1'b0;
          depth_q       <= '0;
        end
        if (ex_enq) begin
          tail_q    <= ring_next(tail_q);
          count_q   <= count_q + CNT_W'(1);
          ceiling_q <= min_ceil;
        end
      end
      if (cmd_i.pop) begin
        head_q  <= ring_next(head_q);
        count_q <= count_q - CNT_W'(1);
        cmp_v_q <= 1'b0;
      end
      if (cmd_i.scan) begin
        cmp_v_q <= rem_q != '0;
        if (rem_q == '0 && !cmp_v_q) ceiling_q <= best_q;
      end
    end
  end

  assign rsp_o = out_q;

endmodule

>>> sv/recursive_mutex_priority_inherit.sv
// Top level of the recursive mutex with FIFO waiters and priority inheritance.
//
// Requests (lock, unlock, try lock with task id and base priority) enter on
// the in_valid_i / in_ready_o channel; exactly one result per request leaves
// on out_valid_o / out_ready_i. The lowest_priority register sits at APB
// address 0; pready is tied high.
//
// Each request passes through the S_EXEC and S_FINISH states before its result
// is registered. A full release that pops a waiter adds the S_POP state and the
// ceiling rescan (S_SCAN), which reads the waiter memory one entry per cycle.
// in_ready_o is high only while no request is in flight, so a new request is
// taken once the previous result has been loaded into the output register.
//
// A stalled receiver holds the result in the output register; the next
// request is still accepted and processed, and waits for the output register
// to free before its result is loaded.
//
// Reset frees the mutex, empties the wait queue and sets the ceiling and
// lowest_priority to 31. The waiter memory is not cleared.
module recursive_mutex_priority_inherit #(
  parameter int MAX_WAITERS = rmpi_pkg::MAX_WAITERS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rmpi_pkg::req_t                    in_req_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rmpi_pkg::rsp_t                    out_rsp_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rmpi_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rmpi_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rmpi_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  logic [rmpi_pkg::PRIO_W-1:0] lowest_prio_q;
  logic                        reg_sel;
  rmpi_pkg::ctrl_cmd_t         cmd;
  rmpi_pkg::dp_sts_t           sts;

  assign pready  = 1'b1;
  assign reg_sel = rmpi_pkg::reg_idx_e'(paddr[2]) == rmpi_pkg::REG_LOWEST_PRIO;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lowest_prio_q <= rmpi_pkg::LOWEST_PRIO_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      lowest_prio_q <= pwdata[rmpi_pkg::PRIO_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel) prdata = rmpi_pkg::APB_DATA_W'(lowest_prio_q);
  end

  rmpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmpi_dp #(
    .MAX_WAITERS (MAX_WAITERS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_req_i      (in_req_i),
    .lowest_prio_i (lowest_prio_q),
    .rsp_o         (out_rsp_o)
  );

endmodule

>>> sv/rmpi_checker.sv
// Port-level assertions for the mutex top level, with their bind.
module rmpi_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input rmpi_pkg::rsp_t out_rsp_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while one is in flight");

  a_resume_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.resume_valid |->
      out_rsp_o.status == rmpi_pkg::ST_RELEASED && out_rsp_o.depth_out == '0)
    else $error("resume without a full release");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_rsp_o.resume_valid || out_rsp_o.resume_task == '0) &&
      (out_rsp_o.set_prio_valid ||
       (out_rsp_o.set_prio_task == '0 && out_rsp_o.set_prio_value == '0)))
    else $error("nonzero field under a clear valid bit");

endmodule

bind recursive_mutex_priority_inherit rmpi_checker u_rmpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

>>> tb/tb_recursive_mutex_priority_inherit.sv
// Self-checking testbench for the recursive priority-inheritance mutex.
`timescale 1ns / 100ps

module tb_recursive_mutex_priority_inherit;
  import rmpi_pkg::*;

  localparam int WIDX_W      = $clog2(MAX_WAITERS);
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE      = MAX_WAITERS + 8;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic                               owned;
    logic [TASK_W-1:0]                  owner;
    logic [PRIO_W-1:0]                  owner_prio;
    logic [DEPTH_W-1:0]                 depth;
    logic [PRIO_W-1:0]                  ceiling;
    logic [MAX_WAITERS-1:0][TASK_W-1:0] wtask;
    logic [MAX_WAITERS-1:0][PRIO_W-1:0] wprio;
    logic [WIDX_W-1:0]                  head;
    logic [WIDX_W-1:0]                  tail;
    logic [WIDX_W:0]                    count;
  } mutex_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  rsp_t        out_rsp_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic        pready;

  req_t        pending_req_q[$];
  rsp_t        expected_rsp_q[$];
  logic [TASK_W-1:0] resumed_task_q[$];
  logic [PRIO_W-1:0] base_prio[NUM_TASKS];
  logic [PRIO_W-1:0] lowest_prio_cfg;
  mutex_t      model_st;
  mutex_t      plan_st;
  idle_mode_e  idle_mode = IDLE_NONE;
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  int          long_hold_left = 0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;

  recursive_mutex_priority_inherit dut (.*);

  // Applies one request to a mutex state and returns the result it gives.
  function automatic rsp_t mutex_apply(inout mutex_t s, input req_t r,
                                       input logic [PRIO_W-1:0] lowest);
    rsp_t              o;
    logic [PRIO_W-1:0] best;
    logic [WIDX_W-1:0] idx;
    int                n;
    o = '0;
    o.status = ST_BUSY;
    case (opcode_e'(r.opcode))
      OP_LOCK, OP_TRYLOCK: begin
        if (!s.owned) begin
          s.owned = 1'b1;
          s.owner = r.requester_task;
          s.owner_prio = r.requester_prio;
          s.depth = DEPTH_W'(1);
          o.status = ST_GRANTED;
        end else if (s.owner == r.requester_task) begin
          if (s.depth >= DEPTH_LIMIT) begin
            o.status = ST_DEPTH_OVF;
          end else begin
            s.depth = s.depth + 1'b1;
            o.status = ST_GRANTED;
          end
        end else if (r.opcode == OP_LOCK) begin
          if (s.count >= MAX_WAITERS) begin
            o.status = ST_QUEUE_FULL;
          end else begin
            s.wtask[s.tail] = r.requester_task;
            s.wprio[s.tail] = r.requester_prio;
            s.tail = WIDX_W'((int'(s.tail) + 1) % MAX_WAITERS);
            s.count = s.count + 1'b1;
            if (r.requester_prio < s.ceiling) s.ceiling = r.requester_prio;
            if (s.owner_prio > s.ceiling) begin
              o.set_prio_valid = 1'b1;
              o.set_prio_task = s.owner;
              o.set_prio_value = s.ceiling;
            end
            o.status = ST_QUEUED;
          end
        end
      end
      OP_UNLOCK: begin
        if (!s.owned || s.owner != r.requester_task) begin
          o.status = ST_NOT_OWNER;
        end else begin
          if (s.depth > 0) s.depth = s.depth - 1'b1;
          if (s.depth > 0) begin
            o.status = ST_PARTIAL;
          end else begin
            s.owned = 1'b0;
            // restore only when the base priority differs from the old ceiling
            if (r.requester_prio != s.ceiling) begin
              o.set_prio_valid = 1'b1;
              o.set_prio_task = r.requester_task;
              o.set_prio_value = r.requester_prio;
            end
            if (s.count > 0) begin
              o.resume_valid = 1'b1;
              o.resume_task = s.wtask[s.head];
              s.head = WIDX_W'((int'(s.head) + 1) % MAX_WAITERS);
              s.count = s.count - 1'b1;
              best = lowest;
              idx = s.head;
              for (n = 0; n < int'(s.count); n++) begin
                if (s.wprio[idx] < best) best = s.wprio[idx];
                idx = WIDX_W'((int'(idx) + 1) % MAX_WAITERS);
              end
              s.ceiling = best;
            end
            o.status = ST_RELEASED;
          end
        end
      end
      default: ;
    endcase
    o.depth_out = s.depth;
    o.ceiling_out = s.ceiling;
    return o;
  endfunction

  // Queues a request and tracks the state it will leave behind.
  task automatic plan_req(input opcode_e op, input logic [TASK_W-1:0] t,
                          input logic [PRIO_W-1:0] p);
    req_t r;
    rsp_t o;
    r.opcode = op;
    r.requester_task = t;
    r.requester_prio = p;
    pending_req_q.push_back(r);
    o = mutex_apply(plan_st, r, lowest_prio_cfg);
    if (o.resume_valid) resumed_task_q.push_back(o.resume_task);
  endtask

  // Releases the mutex and lets every waiter take and drop it in turn.
  task automatic plan_drain();
    logic [TASK_W-1:0] t;
    while (plan_st.owned || plan_st.count != 0) begin
      if (plan_st.owned) begin
        plan_req(OP_UNLOCK, plan_st.owner, plan_st.owner_prio);
      end else begin
        t = resumed_task_q.size() != 0 ? resumed_task_q.pop_front() : TASK_W'($urandom);
        plan_req(OP_LOCK, t, base_prio[t]);
      end
    end
    resumed_task_q.delete();
  endtask

  task automatic plan_random_item();
    int                pick;
    int                sel;
    logic [TASK_W-1:0] t;
    logic [TASK_W-1:0] other;
    logic [PRIO_W-1:0] p;
    pick = $urandom_range(0, 99);
    sel = $urandom_range(0, 9);
    t = TASK_W'($urandom_range(0, NUM_TASKS - 1));
    other = TASK_W'(int'(plan_st.owner) + $urandom_range(1, NUM_TASKS - 1));
    p = PRIO_W'($urandom_range(0, PRIO_LEVELS - 1));
    if (pick < 8) begin
      plan_req(opcode_e'($urandom_range(0, 3)), t, p);
    end else if (resumed_task_q.size() != 0 && pick < 50) begin
      t = resumed_task_q.pop_front();
      plan_req(OP_LOCK, t, base_prio[t]);
    end else if (!plan_st.owned) begin
      plan_req(pick < 75 ? OP_LOCK : OP_TRYLOCK, t, sel < 8 ? base_prio[t] : p);
    end else if (pick < 35) begin
      if (sel < 5) plan_req(OP_UNLOCK, plan_st.owner, plan_st.owner_prio);
      else if (sel < 7) plan_req(OP_UNLOCK, plan_st.owner, plan_st.ceiling);
      else plan_req(OP_UNLOCK, plan_st.owner, p);
    end else if (pick < 47) begin
      plan_req(sel < 5 ? OP_LOCK : OP_TRYLOCK, plan_st.owner, p);
    end else if (pick < 80) begin
      plan_req(OP_LOCK, other, sel < 8 ? base_prio[other] : p);
    end else if (pick < 88) begin
      plan_req(OP_TRYLOCK, other, p);
    end else begin
      plan_req(OP_UNLOCK, other, p);
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_req_q.size() != 0 || in_valid_i || expected_rsp_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_lowest_prio(input logic [PRIO_W-1:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(4 * int'(REG_LOWEST_PRIO));
    pwdata <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    lowest_prio_cfg = v;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [PRIO_W-1:0] cfg, input idle_mode_e mode,
                           input int n_items, input logic hold);
    wait_drained();
    write_lowest_prio(cfg);
    idle_mode = mode;
    foreach (base_prio[i]) base_prio[i] = PRIO_W'($urandom_range(0, PRIO_LEVELS - 1));
    repeat (n_items) plan_random_item();
    long_hold_req = hold;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // request driver and predictor
  always @(posedge clk_i or negedge rst_ni) begin : drive_blk
    logic gap;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_rsp_q.push_back(mutex_apply(model_st, in_req_i, lowest_prio_cfg));
      if (!in_valid_i || in_ready_o) begin
        gap = (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 77) ||
              (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 8);
        if (pending_req_q.size() != 0 && !gap) begin
          in_valid_i <= 1'b1;
          in_req_i <= pending_req_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin : watch_blk
    rsp_t want;
    rsp_t got;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      long_hold_left <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = out_rsp_o;
        if (expected_rsp_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result status %0d depth %0d ceiling %0d", $realtime,
                     got.status, got.depth_out, got.ceiling_out);
        end else begin
          want = expected_rsp_q.pop_front();
          if (got.status !== want.status || got.resume_valid !== want.resume_valid ||
              got.resume_task !== want.resume_task ||
              got.set_prio_valid !== want.set_prio_valid ||
              got.set_prio_task !== want.set_prio_task ||
              got.set_prio_value !== want.set_prio_value ||
              got.depth_out !== want.depth_out || got.ceiling_out !== want.ceiling_out) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: mismatch exp st %0d rs %0b/%0d sp %0b/%0d/%0d dp %0d ce %0d",
                       $realtime, want.status, want.resume_valid, want.resume_task,
                       want.set_prio_valid, want.set_prio_task, want.set_prio_value,
                       want.depth_out, want.ceiling_out);
              $display("%0t:          got st %0d rs %0b/%0d sp %0b/%0d/%0d dp %0d ce %0d",
                       $realtime, got.status, got.resume_valid, got.resume_task,
                       got.set_prio_valid, got.set_prio_task, got.set_prio_value,
                       got.depth_out, got.ceiling_out);
            end
          end
        end
      end
      if (long_hold_left != 0) begin
        long_hold_left <= long_hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        long_hold_left <= LONG_HOLD;
        long_hold_done <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        case (idle_mode)
          IDLE_RECV: out_ready_i <= $urandom_range(0, 99) >= 77;
          IDLE_BOTH: out_ready_i <= $urandom_range(0, 99) >= 8;
          default:   out_ready_i <= 1'b1;
        endcase
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [TASK_W-1:0] t;
    rst_ni <= 1'b0;
    lowest_prio_cfg = LOWEST_PRIO_RST;
    model_st = '0;
    model_st.ceiling = LOWEST_PRIO_RST;
    plan_st = model_st;
    foreach (base_prio[i]) base_prio[i] = PRIO_W'($urandom_range(0, PRIO_LEVELS - 1));
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: error cases, nesting, boost, restore and ceiling rescan
    plan_req(OP_UNLOCK,  4'd0,  5'd0);
    plan_req(OP_NONE,    4'd15, 5'd31);
    plan_req(OP_TRYLOCK, 4'd3,  5'd20);
    plan_req(OP_TRYLOCK, 4'd3,  5'd20);
    plan_req(OP_TRYLOCK, 4'd5,  5'd31);
    plan_req(OP_LOCK,    4'd5,  5'd31);
    plan_req(OP_LOCK,    4'd9,  5'd0);
    plan_req(OP_LOCK,    4'd15, 5'd10);
    plan_req(OP_UNLOCK,  4'd5,  5'd31);
    plan_req(OP_UNLOCK,  4'd3,  5'd20);
    plan_req(OP_UNLOCK,  4'd3,  5'd20);
    plan_req(OP_LOCK,    4'd5,  5'd31);
    plan_req(OP_UNLOCK,  4'd5,  5'd0);
    plan_req(OP_LOCK,    4'd9,  5'd0);
    plan_req(OP_UNLOCK,  4'd9,  5'd0);
    plan_req(OP_LOCK,    4'd15, 5'd10);
    plan_req(OP_UNLOCK,  4'd15, 5'd31);
    plan_req(OP_NONE,    4'd0,  5'd0);
    resumed_task_q.delete();

    // fill the wait queue past its end, then let every waiter through
    t = TASK_W'($urandom_range(0, NUM_TASKS - 1));
    plan_req(OP_LOCK, t, base_prio[t]);
    repeat (MAX_WAITERS + 2)
      plan_req(OP_LOCK, TASK_W'(int'(t) + $urandom_range(1, NUM_TASKS - 1)),
               PRIO_W'($urandom_range(0, PRIO_LEVELS - 1)));
    plan_drain();

    // nest to the depth limit and beyond, then unwind
    t = TASK_W'($urandom_range(0, NUM_TASKS - 1));
    for (int i = 0; i < int'(DEPTH_LIMIT); i++)
      plan_req(i % 2 ? OP_TRYLOCK : OP_LOCK, t, base_prio[t]);
    plan_req(OP_TRYLOCK, t, base_prio[t]);
    plan_req(OP_LOCK, t, base_prio[t]);
    plan_req(OP_LOCK, TASK_W'(int'(t) + 1), 5'd0);
    plan_drain();

    repeat (100) plan_random_item();
    run_phase(5'd0, IDLE_SEND, 80, 1'b0);
    run_phase(5'd15, IDLE_RECV, 80, 1'b0);
    run_phase(PRIO_W'($urandom_range(0, PRIO_LEVELS - 1)), IDLE_BOTH, 80, 1'b0);
    run_phase(5'd31, IDLE_NONE, 60, 1'b1);
    run_phase(PRIO_W'($urandom_range(0, PRIO_LEVELS - 1)), IDLE_NONE, 50, 1'b0);
    plan_drain();

    wait_drained();
    if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
